// File: rtl/core/crs_pkg.sv
// Shared types and constants for the Catmull-Rom segment sampler.
`timescale 1ns / 1ps

package crs_pkg;

    // Width of the step register and its value after reset (about 0.02 in Q0.16).
    localparam int unsigned T_STEP_BITS = 16;
    localparam logic [T_STEP_BITS-1:0] T_STEP_RESET = 16'd1311;

    // Register index of the step register on the configuration port.
    localparam logic REG_T_STEP = 1'b0;

    // Horner step that the shared multiplier performs in a given cycle.
    typedef enum logic [1:0] {
        STEP_H1,
        STEP_H2,
        STEP_H3
    } crs_step_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      accept;
        logic      coef_en;
        logic      mul_en;
        crs_step_t step;
        logic      out_load;
        logic      t_adv;
        logic      shift;
    } crs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic held_full;
        logic t_last;
        logic out_free;
    } crs_status_t;

endpackage

// File: rtl/core/crs_axis.sv
// One coordinate axis: segment coefficients and iterative Horner evaluation.
`timescale 1ns / 1ps

module crs_axis #(
    parameter int unsigned COORD_BITS  = 16,
    parameter int unsigned T_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  crs_pkg::crs_cmd_t             cmd,
    input  logic signed [COORD_BITS-1:0]  p1,
    input  logic signed [COORD_BITS-1:0]  p2,
    input  logic signed [COORD_BITS-1:0]  p3,
    input  logic signed [COORD_BITS-1:0]  p4,
    input  logic        [T_FRAC_BITS-1:0] t,
    output logic signed [COORD_BITS-1:0]  value
);
    import crs_pkg::*;

    // Internal width covers 2*v(t) and all Horner partial results with margin.
    localparam int unsigned W  = COORD_BITS + 6;
    localparam int unsigned PW = W + T_FRAC_BITS + 1;
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (T_FRAC_BITS - 1));
    localparam logic signed [W-1:0] VMAX = W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [W-1:0] VMIN = -VMAX - W'(64'sd1);

    logic signed [W-1:0] e1, e2, e3, e4;
    logic signed [W-1:0] a_reg, b_reg, c_reg, p2x2_reg, h_reg;
    logic signed [W-1:0] a_next, b_next, c_next, h_next;
    logic signed [W-1:0] mul_a;
    logic signed [T_FRAC_BITS:0] mul_b;
    logic signed [PW-1:0] prod, rnd_full;
    logic signed [W-1:0] rnd;
    logic signed [W-1:0] half_w;

    // Sign-extend the four window points.
    assign e1 = W'(p1);
    assign e2 = W'(p2);
    assign e3 = W'(p3);
    assign e4 = W'(p4);

    // Segment coefficients: a = P3-P1, b = 2P1-5P2+4P3-P4, c = -P1+3P2-3P3+P4.
    assign a_next = e3 - e1;
    assign b_next = (e1 <<< 1) - (e2 <<< 2) - e2 + (e3 <<< 2) - e4;
    assign c_next = (e2 <<< 1) + e2 - e1 - (e3 <<< 1) - e3 + e4;

    // Shared multiplier with rounding to the nearest, ties toward plus infinity.
    always_comb begin
        unique case (cmd.step)
            STEP_H1: mul_a = c_reg;
            STEP_H2: mul_a = b_reg + h_reg;
            STEP_H3: mul_a = h_reg;
            default: mul_a = h_reg;
        endcase
    end

    assign mul_b    = signed'({1'b0, t});
    assign prod     = PW'(mul_a) * PW'(mul_b);
    assign rnd_full = (prod + HALF) >>> T_FRAC_BITS;
    assign rnd      = rnd_full[W-1:0];

    // Accumulate the Horner result of each step.
    always_comb begin
        unique case (cmd.step)
            STEP_H1: h_next = rnd;
            STEP_H2: h_next = a_reg + rnd;
            STEP_H3: h_next = p2x2_reg + rnd;
            default: h_next = rnd;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            p2x2_reg <= e2 <<< 1;
        end
        if (cmd.mul_en) begin
            h_reg <= h_next;
        end
    end

    // Halve 2*v(t) with rounding and saturate to the coordinate range.
    assign half_w = (h_reg + W'(64'sd1)) >>> 1;

    always_comb begin
        if (half_w > VMAX) begin
            value = VMAX[COORD_BITS-1:0];
        end else if (half_w < VMIN) begin
            value = VMIN[COORD_BITS-1:0];
        end else begin
            value = half_w[COORD_BITS-1:0];
        end
    end

endmodule

// File: rtl/core/crs_dpath.sv
// Datapath: point window, parameter counter, two axis units and the output register.
`timescale 1ns / 1ps

module crs_dpath #(
    parameter int unsigned COORD_BITS  = 16,
    parameter int unsigned T_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  crs_pkg::crs_cmd_t                    cmd,
    output crs_pkg::crs_status_t                 status,
    input  logic signed [COORD_BITS-1:0]         s_point_x,
    input  logic signed [COORD_BITS-1:0]         s_point_y,
    input  logic                                 s_first_point,
    input  logic [crs_pkg::T_STEP_BITS-1:0]      t_step,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [COORD_BITS-1:0]         m_curve_x,
    output logic signed [COORD_BITS-1:0]         m_curve_y,
    output logic                                 m_last_sample
);
    import crs_pkg::*;

    localparam int unsigned SUMW = ((T_FRAC_BITS > T_STEP_BITS) ? T_FRAC_BITS : T_STEP_BITS) + 2;
    localparam logic [SUMW-1:0] MIN_STEP = SUMW'(1) << (T_FRAC_BITS - 6);
    localparam logic [SUMW-1:0] T_ONE    = SUMW'(1) << T_FRAC_BITS;

    logic signed [COORD_BITS-1:0] win_x_reg [3];
    logic signed [COORD_BITS-1:0] win_y_reg [3];
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [1:0]                   held_reg;
    logic [T_FRAC_BITS-1:0]       t_reg;
    logic [SUMW-1:0]              step_ext, step_eff, t_sum;
    logic signed [COORD_BITS-1:0] vx, vy;
    logic                         out_valid_reg;

    // Window of held points, oldest first; a first point empties it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
            held_reg <= '0;
        end else if (cmd.accept && s_first_point) begin
            for (int i = 0; i < 3; i++) begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
            held_reg <= '0;
        end else if (cmd.shift) begin
            win_x_reg[0] <= win_x_reg[1];
            win_x_reg[1] <= win_x_reg[2];
            win_x_reg[2] <= px_reg;
            win_y_reg[0] <= win_y_reg[1];
            win_y_reg[1] <= win_y_reg[2];
            win_y_reg[2] <= py_reg;
            if (held_reg != 2'd3) begin
                held_reg <= held_reg + 2'd1;
            end
        end
    end

    // Incoming point, held until the segment is done.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg <= s_point_x;
            py_reg <= s_point_y;
        end
    end

    // Parameter counter; the step is clamped so a segment has at most 64 samples.
    assign step_ext = SUMW'(t_step);
    assign step_eff = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
    assign t_sum    = SUMW'(t_reg) + step_eff;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            t_reg <= '0;
        end else if (cmd.t_adv) begin
            t_reg <= t_sum[T_FRAC_BITS-1:0];
        end
    end

    // Axis units share the commands and parameter; each takes its own axis of the window.
    crs_axis #(
        .COORD_BITS (COORD_BITS),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_axis_x (
        .aclk (aclk),
        .cmd  (cmd),
        .p1   (win_x_reg[0]),
        .p2   (win_x_reg[1]),
        .p3   (win_x_reg[2]),
        .p4   (px_reg),
        .t    (t_reg),
        .value(vx)
    );

    crs_axis #(
        .COORD_BITS (COORD_BITS),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_axis_y (
        .aclk (aclk),
        .cmd  (cmd),
        .p1   (win_y_reg[0]),
        .p2   (win_y_reg[1]),
        .p3   (win_y_reg[2]),
        .p4   (py_reg),
        .t    (t_reg),
        .value(vy)
    );

    // Output register holds one sample until the request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_curve_x     <= vx;
            m_curve_y     <= vy;
            m_last_sample <= (t_sum >= T_ONE);
        end
    end

    assign m_valid          = out_valid_reg;
    assign status.held_full = (held_reg == 2'd3);
    assign status.t_last    = (t_sum >= T_ONE);
    assign status.out_free  = !out_valid_reg || m_ready;

endmodule

// File: rtl/core/crs_ctrl.sv
// Controller: sequences one point through coefficient setup, sampling and window shift.
`timescale 1ns / 1ps

module crs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  crs_pkg::crs_status_t status,
    output crs_pkg::crs_cmd_t    cmd
);
    import crs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COEF,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_EMIT,
        ST_SHIFT
    } state_t;

    state_t state_reg;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: state_reg <= status.held_full ? ST_COEF : ST_SHIFT;
                ST_COEF:  state_reg <= ST_H1;
                ST_H1:    state_reg <= ST_H2;
                ST_H2:    state_reg <= ST_H3;
                ST_H3:    state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (status.out_free) begin
                        state_reg <= status.t_last ? ST_SHIFT : ST_H1;
                    end
                end
                ST_SHIFT: state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Command decode from the current state.
    always_comb begin
        cmd          = '0;
        cmd.step     = STEP_H1;
        cmd.accept   = (state_reg == ST_IDLE) && s_valid;
        cmd.coef_en  = (state_reg == ST_COEF);
        cmd.shift    = (state_reg == ST_SHIFT);
        unique case (state_reg)
            ST_H1: begin
                cmd.mul_en = 1'b1;
                cmd.step   = STEP_H1;
            end
            ST_H2: begin
                cmd.mul_en = 1'b1;
                cmd.step   = STEP_H2;
            end
            ST_H3: begin
                cmd.mul_en = 1'b1;
                cmd.step   = STEP_H3;
            end
            ST_EMIT: begin
                cmd.out_load = status.out_free;
                cmd.t_adv    = status.out_free && !status.t_last;
            end
            default: begin
                cmd.mul_en = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/catmull_rom_segment_sampler_top.sv
// Top level of the Catmull-Rom segment sampler: register port, controller and datapath.
//
//   Channel   Direction  Request carries
//   s_        in         point_x, point_y, first_point
//   m_        out        curve_x, curve_y, last_sample
//   APB       in         t_step register (index 0 at byte address 0)
//
// A point that completes a window of four yields N samples before the next point is accepted,
// N being its sample count (at most 64; 50 at the reset step).
// Each sample is made in three Horner steps through the per-axis multiplier
// and then loaded into the output register. A point that starts or fills the window
// is only shifted in, without sampling. A stalled output holds the sampler in its load cycle.
// Reset is synchronous and active low; it clears the window and sets t_step to 1311.
`timescale 1ns / 1ps

module catmull_rom_segment_sampler_top #(
    parameter int unsigned COORD_BITS  = 16,
    parameter int unsigned T_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic                         s_first_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_curve_x,
    output logic signed [COORD_BITS-1:0] m_curve_y,
    output logic                         m_last_sample,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import crs_pkg::*;

    logic [T_STEP_BITS-1:0] t_step_reg;
    logic                   cfg_write;
    crs_cmd_t               cmd;
    crs_status_t            status;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_T_STEP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_step_reg <= T_STEP_RESET;
        end else if (cfg_write) begin
            t_step_reg <= pwdata[T_STEP_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_T_STEP) ? {{(32 - T_STEP_BITS){1'b0}}, t_step_reg} : '0;

    crs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    crs_dpath #(
        .COORD_BITS (COORD_BITS),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_first_point(s_first_point),
        .t_step       (t_step_reg),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_curve_x    (m_curve_x),
        .m_curve_y    (m_curve_y),
        .m_last_sample(m_last_sample)
    );

`ifndef SYNTHESIS
    // An accepted point keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a point was accepted");

    // A sample is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten while a request was pending");

    // A register write lands in t_step.
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> t_step_reg == $past(pwdata[T_STEP_BITS-1:0]))
        else $error("t_step write lost");
`endif

endmodule

// File: tb/spline_sample_checker.sv
// Checker for the Catmull-Rom segment sampler: predicts curve samples and compares them.
`timescale 1ns / 1ps

module spline_sample_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic               s_first_point,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_curve_x,
    input  logic signed [15:0] m_curve_y,
    input  logic               m_last_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 mismatch_count,
    output int                 samples_outstanding
);
    import crs_pkg::*;

    localparam int     COORD_BITS  = 16;
    localparam int     T_FRAC_BITS = 16;
    localparam longint T_UNIT      = longint'(1) << T_FRAC_BITS;
    localparam longint MIN_STEP    = T_UNIT >>> 6;
    localparam int     MAX_SAMPLES = 64;
    localparam longint COORD_MAX   = 32767;
    localparam longint COORD_MIN   = -32768;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } curve_sample_t;

    curve_sample_t            expected_samples[$];
    logic [T_STEP_BITS-1:0]   step_reg;
    longint                   hist_x[3];
    longint                   hist_y[3];
    int                       points_in_window;

    // Rounds a product in units of 2^-T_FRAC_BITS to the nearest integer, ties upward.
    function automatic longint round_t(input longint v);
        return (v + (T_UNIT >>> 1)) >>> T_FRAC_BITS;
    endfunction

    // One axis of the segment, evaluated in Horner form on twice the curve value.
    function automatic logic signed [COORD_BITS-1:0] interpolate(
        input longint p1, input longint p2, input longint p3, input longint p4,
        input longint t
    );
        longint a, b, c, h1, h3, w, v;
        a  = p3 - p1;
        b  = 2 * p1 - 5 * p2 + 4 * p3 - p4;
        c  = -p1 + 3 * p2 - 3 * p3 + p4;
        h1 = round_t(c * t);
        h3 = a + round_t((b + h1) * t);
        w  = 2 * p2 + round_t(h3 * t);
        v  = (w + 1) >>> 1;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    // Queues every sample of the segment that ends at the new point.
    task automatic queue_segment(input longint px, input longint py);
        longint        step;
        longint        t;
        int            n;
        curve_sample_t s;
        step = longint'(step_reg);
        // Steps below 1/64 are clamped so a segment never exceeds 64 samples.
        if (step < MIN_STEP) step = MIN_STEP;
        n = 0;
        for (t = 0; t < T_UNIT && n < MAX_SAMPLES; t += step) begin
            s.x    = interpolate(hist_x[0], hist_x[1], hist_x[2], px, t);
            s.y    = interpolate(hist_y[0], hist_y[1], hist_y[2], py, t);
            s.last = (t + step >= T_UNIT);
            expected_samples.push_back(s);
            n++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        curve_sample_t want;
        longint        px;
        longint        py;
        if (!aresetn) begin
            expected_samples.delete();
            step_reg         = T_STEP_RESET;
            hist_x           = '{0, 0, 0};
            hist_y           = '{0, 0, 0};
            points_in_window = 0;
            mismatch_count   = 0;
        end else begin
            // Register writes; the spare register index is ignored by the block.
            if (psel && penable && pwrite && pready && paddr[2] == REG_T_STEP) begin
                step_reg = pwdata[T_STEP_BITS-1:0];
            end

            // Accepted control point: a curve start empties the window first.
            if (s_valid && s_ready) begin
                px = s_point_x;
                py = s_point_y;
                if (s_first_point) begin
                    hist_x           = '{0, 0, 0};
                    hist_y           = '{0, 0, 0};
                    points_in_window = 0;
                end
                if (points_in_window >= 3) queue_segment(px, py);
                hist_x[0] = hist_x[1];
                hist_x[1] = hist_x[2];
                hist_x[2] = px;
                hist_y[0] = hist_y[1];
                hist_y[1] = hist_y[2];
                hist_y[2] = py;
                if (points_in_window < 3) points_in_window++;
            end

            // Accepted curve sample: compare with the oldest prediction.
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected curve sample x=%0d y=%0d last=%0d",
                           m_curve_x, m_curve_y, m_last_sample);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_curve_x !== want.x) begin
                        $error("curve_x: expected %0d, got %0d", want.x, m_curve_x);
                        mismatch_count++;
                    end
                    if (m_curve_y !== want.y) begin
                        $error("curve_y: expected %0d, got %0d", want.y, m_curve_y);
                        mismatch_count++;
                    end
                    if (m_last_sample !== want.last) begin
                        $error("last_sample: expected %0d, got %0d", want.last,
                               m_last_sample);
                        mismatch_count++;
                    end
                end
            end
        end
        samples_outstanding = expected_samples.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the sampler testbench: clock, reset, point and register stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import crs_pkg::*;

    // Slowest run: ~410 points at 64 samples each, every sample stalled the longest.
    localparam int LIMIT_CYCLES     = 2_000_000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int TAIL_CYCLES      = 40;
    localparam int HOLD_AFTER       = 700;
    localparam int LONG_HOLD_CYCLES = 900;
    localparam int PHASE_POINTS     = 37;
    localparam logic [2:0] T_STEP_ADDR = {REG_T_STEP, 2'b00};
    localparam logic [2:0] SPARE_ADDR  = {~REG_T_STEP, 2'b00};

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_point_x;
    logic signed [15:0] s_point_y;
    logic               s_first_point;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_curve_x;
    logic signed [15:0] m_curve_y;
    logic               m_last_sample;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int mismatch_count;
    int samples_outstanding;
    int cycle_count;
    bit sender_calm;
    bit receiver_calm;

    catmull_rom_segment_sampler_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_first_point (s_first_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_curve_x     (m_curve_x),
        .m_curve_y     (m_curve_y),
        .m_last_sample (m_last_sample),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    spline_sample_checker checker_inst (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_point_x           (s_point_x),
        .s_point_y           (s_point_y),
        .s_first_point       (s_first_point),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_curve_x           (m_curve_x),
        .m_curve_y           (m_curve_y),
        .m_last_sample       (m_last_sample),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .mismatch_count      (mismatch_count),
        .samples_outstanding (samples_outstanding)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Writes one register through a setup and an access cycle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one control point after a random gap and waits for its request to be taken.
    task automatic offer_point(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic first);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_point_x     <= x;
        s_point_y     <= y;
        s_first_point <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every predicted sample has come out.
    task automatic drain_samples;
        s_valid <= 1'b0;
        while (samples_outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Coordinates weighted toward the extremes and toward small values.
    function automatic logic signed [15:0] pick_coord;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return r[15:0] % 16'd1024 - 16'd512;
            default: return r[15:0];
        endcase
    endfunction

    // Mostly well-formed curves of four or more points, plus short and broken runs.
    task automatic random_curves(input int count);
        int sent_here;
        int len;
        sent_here = 0;
        while (sent_here < count) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) != 0) begin
                len = $urandom_range(4, 10);
                for (int i = 0; i < len; i++) offer_point(pick_coord(), pick_coord(), i == 0);
            end else begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    offer_point(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
                end
            end
            sent_here += len;
        end
    endtask

    // Changes the step between phases, with random upper bits that the block drops.
    task automatic set_step(input logic [15:0] step);
        logic [31:0] word;
        drain_samples();
        word       = $urandom;
        word[15:0] = step;
        write_reg(T_STEP_ADDR, word);
    endtask

    // Result side: random stalls per sample, calm stretches, and one long hold-off.
    initial begin : result_side
        int wait_cycles;
        int taken;
        taken         = 0;
        receiver_calm = 1'b0;
        m_ready       = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (taken % 64 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AFTER) begin
                wait_cycles = LONG_HOLD_CYCLES;
            end else begin
                wait_cycles = receiver_calm ? 0 : $urandom_range(0, 13);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
            taken++;
        end
    end

    // Point side and verdict.
    initial begin : point_side
        s_valid       = 1'b0;
        s_point_x     = '0;
        s_point_y     = '0;
        s_first_point = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sender_calm   = 1'b0;
        aresetn       = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: saturating extremes at the reset step.
        offer_point(16'sd0, 16'sd0, 1'b1);
        offer_point(16'sd256, -16'sd256, 1'b0);
        offer_point(16'sh7FFF, 16'sh8000, 1'b0);
        offer_point(16'sh8000, 16'sh7FFF, 1'b0);
        offer_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        offer_point(16'sh8000, 16'sh8000, 1'b0);
        // A curve start on a full window discards it; a short curve emits nothing.
        offer_point(16'sd0, 16'sd0, 1'b1);
        offer_point(16'sd1, 16'sd1, 1'b0);
        offer_point(16'sd100, -16'sd100, 1'b1);
        offer_point(16'sd200, -16'sd50, 1'b0);
        offer_point(16'sd300, 16'sd0, 1'b0);
        offer_point(16'sd400, 16'sd75, 1'b0);
        offer_point(-16'sd1, -16'sd1, 1'b0);
        offer_point(16'sh5555, 16'shAAAA, 1'b0);

        // A write to the spare register index must leave the step alone.
        drain_samples();
        write_reg(SPARE_ADDR, $urandom);
        random_curves(PHASE_POINTS);

        // Step sweep: clamped, near one, clamp edge, coarse, random, then back to the reset step.
        set_step(16'd0);
        random_curves(PHASE_POINTS);
        set_step(16'd65535);
        random_curves(PHASE_POINTS);
        set_step(16'd1023);
        random_curves(PHASE_POINTS);
        set_step(16'd1024);
        random_curves(PHASE_POINTS);
        set_step(16'd32768);
        random_curves(PHASE_POINTS);
        set_step(16'd21846);
        random_curves(PHASE_POINTS);
        set_step(16'($urandom_range(1024, 65535)));
        random_curves(PHASE_POINTS);
        set_step(16'($urandom_range(0, 65535)));
        random_curves(PHASE_POINTS);
        set_step(T_STEP_RESET);
        random_curves(PHASE_POINTS);

        s_valid <= 1'b0;
        while (samples_outstanding != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && samples_outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/crs_pkg.sv
rtl/core/crs_axis.sv
rtl/core/crs_dpath.sv
rtl/core/crs_ctrl.sv
rtl/core/catmull_rom_segment_sampler_top.sv
tb/spline_sample_checker.sv
tb/tb_top.sv
